@@ hw/rtl/cbe_pkg.sv @@
// Shared constants, control word types and the microcode program of the cubic Bezier easing block.
`default_nettype none

package cbe_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int SEARCH_STEPS = 17;

   localparam int VAL_W = 19;              // signed time / value / y control fields
   localparam int X_W   = 17;              // unsigned x control fields
   localparam int S_W   = FRAC_BITS + 1;   // curve parameter in [0, ONE]
   localparam int U3_W  = S_W + 2;         // 3 * (ONE - s)
   localparam int A_W   = 20;              // multiplier operand A, signed
   localparam int B_W   = 21;              // multiplier operand B, signed
   localparam int P_W   = A_W + B_W;       // product and accumulator
   localparam int CNT_W = $clog2(SEARCH_STEPS + 1);
   localparam int PC_W  = 5;
   localparam int IDX_W = 2;

   localparam int ONE_Q = 1 << FRAC_BITS;

   localparam logic [PC_W-1:0] PC_ACCEPT = PC_W'(0);
   localparam logic [PC_W-1:0] PC_MID    = PC_W'(1);
   localparam logic [PC_W-1:0] PC_XEVAL  = PC_W'(2);
   localparam logic [PC_W-1:0] PC_DECIDE = PC_W'(9);
   localparam logic [PC_W-1:0] PC_YEVAL  = PC_W'(10);
   localparam logic [PC_W-1:0] PC_FINISH = PC_W'(17);

   localparam logic [IDX_W-1:0] REG_X1 = IDX_W'(0);
   localparam logic [IDX_W-1:0] REG_Y1 = IDX_W'(1);
   localparam logic [IDX_W-1:0] REG_X2 = IDX_W'(2);
   localparam logic [IDX_W-1:0] REG_Y2 = IDX_W'(3);

   typedef enum logic [2:0] {
      SEQ_NEXT,
      SEQ_ACCEPT,
      SEQ_MID,
      SEQ_DECIDE,
      SEQ_FINISH,
      SEQ_JUMP
   } seq_op_type;

   typedef enum logic [1:0] {
      A_P1,
      A_P2,
      A_U3,
      A_S
   } asel_type;

   typedef enum logic [1:0] {
      B_U,
      B_S,
      B_ACC_SH,
      B_ACC
   } bsel_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_LOAD_SH,
      ACC_ADD_SH
   } acc_op_type;

   typedef enum logic {
      PSEL_X,
      PSEL_Y
   } psel_type;

   typedef struct packed {
      seq_op_type      seq_op;
      logic [PC_W-1:0] branch_pc;
      psel_type        psel;
      asel_type        a_sel;
      bsel_type        b_sel;
      acc_op_type      acc_op;
   } ucode_type;

   // One curve evaluation: inner, s*s, 3*u*inner, sum, s*sum.
   function automatic ucode_type eval_word(input logic [2:0] step, input psel_type psel);
      ucode_type w;
      w.seq_op    = SEQ_NEXT;
      w.branch_pc = PC_ACCEPT;
      w.psel      = psel;
      w.a_sel     = A_S;
      w.b_sel     = B_S;
      w.acc_op    = ACC_HOLD;
      case (step)
         3'd0: begin
            w.a_sel = A_P1;
            w.b_sel = B_U;
         end
         3'd1: begin
            w.a_sel  = A_P2;
            w.b_sel  = B_S;
            w.acc_op = ACC_LOAD;
         end
         3'd2: begin
            w.a_sel  = A_S;
            w.b_sel  = B_S;
            w.acc_op = ACC_ADD;
         end
         3'd3: begin
            w.a_sel  = A_U3;
            w.b_sel  = B_ACC_SH;
            w.acc_op = ACC_LOAD_SH;
         end
         3'd4: begin
            w.acc_op = ACC_ADD_SH;
         end
         3'd5: begin
            w.a_sel = A_S;
            w.b_sel = B_ACC;
         end
         3'd6: begin
            w.acc_op = ACC_LOAD_SH;
         end
         default: begin
            w.acc_op = ACC_HOLD;
         end
      endcase
      return w;
   endfunction

   function automatic ucode_type ucode_fetch(input logic [PC_W-1:0] pc);
      ucode_type w;
      w.seq_op    = SEQ_NEXT;
      w.branch_pc = PC_ACCEPT;
      w.psel      = PSEL_X;
      w.a_sel     = A_S;
      w.b_sel     = B_S;
      w.acc_op    = ACC_HOLD;
      if (pc >= PC_XEVAL && pc < PC_DECIDE) begin
         w = eval_word(3'(pc - PC_XEVAL), PSEL_X);
      end else if (pc >= PC_YEVAL && pc < PC_FINISH) begin
         w = eval_word(3'(pc - PC_YEVAL), PSEL_Y);
      end else begin
         case (pc)
            PC_ACCEPT: begin
               w.seq_op    = SEQ_ACCEPT;
               w.branch_pc = PC_FINISH;
            end
            PC_MID: begin
               w.seq_op = SEQ_MID;
            end
            PC_DECIDE: begin
               w.seq_op    = SEQ_DECIDE;
               w.branch_pc = PC_MID;
            end
            PC_FINISH: begin
               w.seq_op    = SEQ_FINISH;
               w.branch_pc = PC_ACCEPT;
            end
            default: begin
               w.seq_op    = SEQ_JUMP;
               w.branch_pc = PC_ACCEPT;
            end
         endcase
      end
      return w;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cubic_bezier_easing.sv @@
// Cubic Bezier easing curve evaluator, run by a microcoded sequencer over one multiplier.
//
//   channel  ports                         direction  content
//   req      req_valid/req_stall           in         time_in, signed Q16
//   rsp      rsp_valid/rsp_stall           out        eased_value, signed Q16 saturated
//   csr      csr_write_en/index/wdata      in         control points x1, y1, x2, y2
//
// A time at or outside [0,1], or a linear curve, goes from accept straight to finish.
// A bisected item runs accept, then up to 17 search steps (each mid, seven multiplier
// steps, decision), then the y evaluation and finish.
// Reset is synchronous; it clears the sequencer and output valid, and loads default points.
// The next item is taken while a result waits in the output register; a stalled result
// holds the sequencer at its finish step.
`default_nettype none

module cubic_bezier_easing (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic signed [cbe_pkg::VAL_W-1:0]   req_time_in,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [cbe_pkg::VAL_W-1:0]        rsp_eased_value,
   input  wire logic                               csr_write_en,
   input  wire logic [cbe_pkg::IDX_W-1:0]          csr_index,
   input  wire logic [cbe_pkg::VAL_W-1:0]          csr_wdata
);
   import cbe_pkg::*;

   localparam logic signed [P_W-1:0]   SAT_LO = P_W'(-2 * ONE_Q);
   localparam logic signed [P_W-1:0]   SAT_HI = P_W'(3 * ONE_Q);
   localparam logic signed [P_W-1:0]   ONE_P  = P_W'(ONE_Q);
   localparam logic signed [VAL_W-1:0] ONE_V  = VAL_W'(ONE_Q);
   localparam logic [S_W-1:0]          ONE_S  = S_W'(ONE_Q);

   ucode_type ctl;

   logic [PC_W-1:0]         pc_ff, pc_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic [X_W-1:0]          x1_ff, x1_in, x2_ff, x2_in;
   logic signed [VAL_W-1:0] y1_ff, y1_in, y2_ff, y2_in;
   logic signed [VAL_W-1:0] t_ff, t_in;
   logic [S_W-1:0]          left_ff, left_in, right_ff, right_in;
   logic [S_W-1:0]          s_ff, s_in, u_ff, u_in;
   logic [U3_W-1:0]         u3_ff, u3_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in, cnt_nx;
   logic signed [P_W-1:0]   prod_ff, prod_in, acc_ff, acc_in, acc_sat;
   logic signed [A_W-1:0]   mul_a, p1, p2;
   logic signed [B_W-1:0]   mul_b;
   logic [S_W:0]            mid_sum;
   logic                    req_fire, out_free, finish_fire, linear, hit, search_done;

   always_comb begin
      ctl       = ucode_fetch(pc_ff);
      req_stall = (ctl.seq_op != SEQ_ACCEPT);
      req_fire  = req_valid && !req_stall;
      out_free  = !rsp_valid_ff || !rsp_stall;
      finish_fire = (ctl.seq_op == SEQ_FINISH) && out_free;
      linear    = ($signed({2'b00, x1_ff}) == y1_ff) && ($signed({2'b00, x2_ff}) == y2_ff);

      x1_in = x1_ff;
      y1_in = y1_ff;
      x2_in = x2_ff;
      y2_in = y2_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_X1:  x1_in = csr_wdata[X_W-1:0];
            REG_Y1:  y1_in = csr_wdata;
            REG_X2:  x2_in = csr_wdata[X_W-1:0];
            REG_Y2:  y2_in = csr_wdata;
            default: x1_in = x1_ff;
         endcase
      end

      if (ctl.psel == PSEL_X) begin
         p1 = A_W'(x1_ff);
         p2 = A_W'(x2_ff);
      end else begin
         p1 = A_W'(y1_ff);
         p2 = A_W'(y2_ff);
      end

      case (ctl.a_sel)
         A_P1:    mul_a = p1;
         A_P2:    mul_a = p2;
         A_U3:    mul_a = A_W'(u3_ff);
         A_S:     mul_a = A_W'(s_ff);
         default: mul_a = '0;
      endcase
      case (ctl.b_sel)
         B_U:      mul_b = B_W'(u_ff);
         B_S:      mul_b = B_W'(s_ff);
         B_ACC_SH: mul_b = acc_ff[FRAC_BITS +: B_W];
         B_ACC:    mul_b = acc_ff[B_W-1:0];
         default:  mul_b = '0;
      endcase
      prod_in = mul_a * mul_b;
      u3_in   = U3_W'(u_ff) + U3_W'({u_ff, 1'b0});

      case (ctl.acc_op)
         ACC_LOAD:    acc_in = prod_ff;
         ACC_ADD:     acc_in = acc_ff + prod_ff;
         ACC_LOAD_SH: acc_in = prod_ff >>> FRAC_BITS;
         ACC_ADD_SH:  acc_in = acc_ff + (prod_ff >>> FRAC_BITS);
         default:     acc_in = acc_ff;
      endcase

      t_in     = t_ff;
      left_in  = left_ff;
      right_in = right_ff;
      s_in     = s_ff;
      u_in     = u_ff;
      cnt_in   = cnt_ff;
      cnt_nx   = cnt_ff + CNT_W'(1);
      mid_sum  = {1'b0, left_ff} + {1'b0, right_ff};
      hit      = (acc_ff == P_W'(t_ff));
      search_done = hit || (cnt_nx == CNT_W'(SEARCH_STEPS));
      pc_in    = pc_ff + PC_W'(1);

      case (ctl.seq_op)
         SEQ_ACCEPT: begin
            pc_in = pc_ff;
            if (req_fire) begin
               t_in     = req_time_in;
               left_in  = '0;
               right_in = ONE_S;
               cnt_in   = '0;
               if (req_time_in <= 0) begin
                  acc_in = '0;
                  pc_in  = ctl.branch_pc;
               end else if (req_time_in >= ONE_V) begin
                  acc_in = ONE_P;
                  pc_in  = ctl.branch_pc;
               end else if (linear) begin
                  acc_in = P_W'(req_time_in);
                  pc_in  = ctl.branch_pc;
               end else begin
                  pc_in = pc_ff + PC_W'(1);
               end
            end
         end
         SEQ_MID: begin
            s_in = mid_sum[S_W:1];
            u_in = ONE_S - mid_sum[S_W:1];
         end
         SEQ_DECIDE: begin
            cnt_in = cnt_nx;
            if (acc_ff < P_W'(t_ff)) begin
               left_in = s_ff;
            end else begin
               right_in = s_ff;
            end
            if (!search_done) begin
               pc_in = ctl.branch_pc;
            end
         end
         SEQ_FINISH: begin
            pc_in = finish_fire ? ctl.branch_pc : pc_ff;
         end
         SEQ_JUMP: begin
            pc_in = ctl.branch_pc;
         end
         default: begin
            pc_in = pc_ff + PC_W'(1);
         end
      endcase

      if (acc_ff < SAT_LO) begin
         acc_sat = SAT_LO;
      end else if (acc_ff > SAT_HI) begin
         acc_sat = SAT_HI;
      end else begin
         acc_sat = acc_ff;
      end

      rsp_value_in = rsp_value_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (finish_fire) begin
         rsp_value_in = acc_sat[VAL_W-1:0];
         rsp_valid_in = 1'b1;
      end

      rsp_valid       = rsp_valid_ff;
      rsp_eased_value = rsp_value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_ACCEPT;
         rsp_valid_ff <= 1'b0;
         x1_ff        <= '0;
         y1_ff        <= '0;
         x2_ff        <= X_W'(ONE_Q);
         y2_ff        <= ONE_V;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         x1_ff        <= x1_in;
         y1_ff        <= y1_in;
         x2_ff        <= x2_in;
         y2_ff        <= y2_in;
      end
      rsp_value_ff <= rsp_value_in;
      t_ff         <= t_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      s_ff         <= s_in;
      u_ff         <= u_in;
      u3_ff        <= u3_in;
      cnt_ff       <= cnt_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
   end

`ifndef SYNTHESIS
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctl.seq_op == SEQ_FINISH))
      else $error("result raised outside the finish step");

   a_finish_returns: assert property (@(posedge clock) disable iff (reset)
      finish_fire |=> (pc_ff == PC_ACCEPT) && rsp_valid_ff)
      else $error("finish step did not hand off the result");

   a_bracket_order: assert property (@(posedge clock) disable iff (reset)
      (pc_ff != PC_ACCEPT) && (pc_ff < PC_YEVAL) |-> (left_ff <= right_ff))
      else $error("bisection bracket inverted");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (ctl.seq_op == SEQ_DECIDE) |-> (cnt_ff < CNT_W'(SEARCH_STEPS)))
      else $error("search ran past its step count");
`endif

endmodule

`default_nettype wire

@@ verif/cubic_bezier_easing_tb.sv @@
// Self-checking testbench for the cubic Bezier easing block: directed shapes, back-pressure and random curves.
`timescale 1ns / 1ps

module cubic_bezier_easing_tb;
   import cbe_pkg::*;

   typedef logic signed [VAL_W-1:0] val_type;

   localparam int  HOLD_CYCLES = 300;
   localparam int  TAIL_CYCLES = 200;
   localparam int  LIMIT       = 1500000;
   localparam int  RAND_SETS   = 8;
   localparam int  SET_ITEMS   = 150;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   val_type               req_time_in = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   val_type               rsp_eased_value;
   logic                  csr_write_en = 1'b0;
   logic [IDX_W-1:0]      csr_index = '0;
   logic [VAL_W-1:0]      csr_wdata = '0;

   // control point mirror
   logic [X_W-1:0]        cfg_x1 = '0;
   val_type               cfg_y1 = '0;
   logic [X_W-1:0]        cfg_x2 = X_W'(ONE_Q);
   val_type               cfg_y2 = val_type'(ONE_Q);

   val_type               eased_expected[$];
   val_type               eased_front;
   int                    errors = 0;
   int                    items_sent = 0;
   int                    reg_writes = 0;
   int                    cycles = 0;
   int                    send_idle_pct = 0;
   int                    recv_stall_pct = 0;
   int                    hold_requests = 0;
   int                    hold_served = 0;
   int                    hold_left = 0;

   cubic_bezier_easing DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_time_in     (req_time_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_eased_value (rsp_eased_value),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint bezier_coord(input longint p1, input longint p2, input longint s);
      longint u;
      longint inner;
      longint sum;
      u     = longint'(ONE_Q) - s;
      inner = (p1 * u + p2 * s) >>> FRAC_BITS;
      sum   = ((3 * u * inner) >>> FRAC_BITS) + ((s * s) >>> FRAC_BITS);
      return (s * sum) >>> FRAC_BITS;
   endfunction

   function automatic val_type ease_time(input val_type t);
      longint tv;
      longint y;
      longint lo;
      longint hi;
      longint mid;
      longint xe;
      bit     hit;
      tv = t;
      if (tv <= 0) begin
         y = 0;
      end else if (tv >= ONE_Q) begin
         y = ONE_Q;
      end else if (longint'(cfg_x1) == longint'(cfg_y1) && longint'(cfg_x2) == longint'(cfg_y2)) begin
         y = tv;
      end else begin
         lo  = 0;
         hi  = ONE_Q;
         mid = 0;
         hit = 1'b0;
         for (int i = 0; i < SEARCH_STEPS && !hit; i++) begin
            mid = (lo + hi) >>> 1;
            xe  = bezier_coord(longint'(cfg_x1), longint'(cfg_x2), mid);
            if (xe == tv) hit = 1'b1;
            else if (xe < tv) lo = mid;
            else hi = mid;
         end
         y = bezier_coord(longint'(cfg_y1), longint'(cfg_y2), mid);
      end
      if (y < -2 * longint'(ONE_Q)) y = -2 * longint'(ONE_Q);
      if (y > 3 * longint'(ONE_Q)) y = 3 * longint'(ONE_Q);
      return val_type'(y);
   endfunction

   function automatic val_type pick_x();
      case ($urandom_range(5))
         0: return val_type'(0);
         1: return val_type'(ONE_Q);
         2: return val_type'(2 * ONE_Q - 1);
         3: return val_type'($urandom);
         default: return val_type'($urandom_range(ONE_Q));
      endcase
   endfunction

   function automatic val_type pick_y();
      case ($urandom_range(6))
         0: return val_type'(-2 * ONE_Q);
         1: return val_type'(3 * ONE_Q);
         2: return val_type'(-4 * ONE_Q);
         3: return val_type'(4 * ONE_Q - 1);
         4: return val_type'($urandom);
         default: return val_type'(int'($urandom_range(5 * ONE_Q)) - 2 * ONE_Q);
      endcase
   endfunction

   function automatic val_type pick_time();
      case ($urandom_range(9))
         0: return val_type'($urandom);
         1: begin
            case ($urandom_range(4))
               0: return val_type'(0);
               1: return val_type'(1);
               2: return val_type'(ONE_Q - 1);
               3: return val_type'(ONE_Q);
               default: return val_type'(-1);
            endcase
         end
         default: return val_type'($urandom_range(ONE_Q - 1, 1));
      endcase
   endfunction

   task automatic set_idle(input int phase);
      case (phase)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
         default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
   endtask

   task automatic send_time(input val_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_time_in <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      eased_expected.push_back(ease_time(t));
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (eased_expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         REG_X1: cfg_x1 = val[X_W-1:0];
         REG_Y1: cfg_y1 = val_type'(val);
         REG_X2: cfg_x2 = val[X_W-1:0];
         REG_Y2: cfg_y2 = val_type'(val);
         default: ;
      endcase
      reg_writes++;
   endtask

   task automatic write_curve(input val_type x1, input val_type y1, input val_type x2,
                              input val_type y2);
      write_reg(REG_X1, x1);
      write_reg(REG_Y1, y1);
      write_reg(REG_X2, x2);
      write_reg(REG_Y2, y2);
   endtask

   // reset curve is linear; clamping at both ends and full-width times
   task automatic test_reset_curve();
      set_idle(0);
      send_time(val_type'(-4 * ONE_Q));
      send_time(val_type'(-1));
      send_time(val_type'(0));
      send_time(val_type'(1));
      send_time(val_type'(ONE_Q / 2));
      send_time(val_type'(ONE_Q - 1));
      send_time(val_type'(ONE_Q));
      send_time(val_type'(4 * ONE_Q - 1));
      wait_idle();
   endtask

   task automatic test_directed_shapes();
      // symmetric curve: midpoint hits exactly on the first probe
      write_curve(val_type'(ONE_Q / 4), val_type'(0), val_type'(3 * ONE_Q / 4),
                  val_type'(ONE_Q));
      send_time(val_type'(ONE_Q / 2));
      send_time(val_type'(1));
      send_time(val_type'(20000));
      send_time(val_type'(ONE_Q - 1));
      wait_idle();
      // x beyond one, non-monotonic, y at full-width extremes
      write_curve(val_type'(2 * ONE_Q - 1), val_type'(4 * ONE_Q - 1), val_type'(0),
                  val_type'(-4 * ONE_Q));
      send_time(val_type'(1));
      send_time(val_type'(30000));
      send_time(val_type'(ONE_Q - 1));
      wait_idle();
      // high y pulls the curve above one, though not as far as the upper clamp
      write_curve(val_type'(0), val_type'(3 * ONE_Q), val_type'(ONE_Q), val_type'(3 * ONE_Q));
      send_time(val_type'(ONE_Q / 2));
      send_time(val_type'(20000));
      wait_idle();
      // equal pairs off the default points still take the linear path
      write_curve(val_type'(100), val_type'(100), val_type'(70000), val_type'(70000));
      send_time(val_type'(5));
      send_time(val_type'(40000));
      wait_idle();
   endtask

   task automatic test_backpressure();
      write_curve(val_type'(ONE_Q / 4), val_type'(ONE_Q / 10), val_type'(ONE_Q / 4),
                  val_type'(ONE_Q));
      set_idle(0);
      hold_requests++;
      for (int i = 0; i < 16; i++) send_time(pick_time());
      wait_idle();
   endtask

   task automatic test_random_curves();
      val_type x1;
      val_type x2;
      for (int k = 0; k < RAND_SETS; k++) begin
         if (k == 0) begin
            write_curve(val_type'(0), val_type'(-2 * ONE_Q), val_type'(ONE_Q),
                        val_type'(3 * ONE_Q));
         end else if (k == RAND_SETS - 1) begin
            write_curve(val_type'(2 * ONE_Q - 1), val_type'(-4 * ONE_Q),
                        val_type'(2 * ONE_Q - 1), val_type'(4 * ONE_Q - 1));
         end else if (k == 3) begin
            x1 = pick_x();
            x2 = pick_x();
            write_curve(x1, val_type'({2'b00, x1[X_W-1:0]}), x2,
                        val_type'({2'b00, x2[X_W-1:0]}));
         end else begin
            write_curve(pick_x(), pick_y(), pick_x(), pick_y());
         end
         for (int j = 0; j < SET_ITEMS; j++) begin
            if (j % 50 == 0) set_idle((k + j / 50) % 4);
            if (k == 5 && j == SET_ITEMS / 2) wait_idle();
            send_time(pick_time());
         end
         wait_idle();
      end
   endtask

   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (eased_expected.size() == 0) begin
            $display("%0t: result %0d with no transfer outstanding", $time, rsp_eased_value);
            errors++;
         end else begin
            eased_front = eased_expected.pop_front();
            if (rsp_eased_value !== eased_front) begin
               $display("%0t: eased_value mismatch, expected %0d actual %0d",
                        $time, eased_front, rsp_eased_value);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, eased_expected.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_curve();
      test_directed_shapes();
      test_backpressure();
      test_random_curves();
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d time transfers across %0d register writes: linear, eased,",
               items_sent, reg_writes);
      $display("non-monotonic and saturating curves under idle, stall and hold-off mixes");
      if (errors == 0 && eased_expected.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
